// ----- sv/json_string_escaper_unit_assert.svh -----
// Assertion macros used by the string escaper back end.
`ifndef JSON_STRING_ESCAPER_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while in reset.
`define JSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jse: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while in reset.
`define JSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jse: next-cycle check failed");

`endif

// ----- sv/jse_pkg.sv -----
// Shared types, character codes and helpers for the string escaper.
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

	// Descriptor queue depth and derived widths
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// How the body of one item expands
	localparam logic [1:0] KIND_NONE = 2'd0; // no byte
	localparam logic [1:0] KIND_RAW  = 2'd1; // byte as is
	localparam logic [1:0] KIND_ESC  = 2'd2; // backslash + letter
	localparam logic [1:0] KIND_UNI  = 2'd3; // \u00 + two hex digits

	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_SLASH = 8'h2F;
	localparam logic [7:0] CHR_BS = 8'h08;
	localparam logic [7:0] CHR_FF = 8'h0C;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_LOW_B = 8'h62;
	localparam logic [7:0] CHR_LOW_F = 8'h66;
	localparam logic [7:0] CHR_LOW_N = 8'h6E;
	localparam logic [7:0] CHR_LOW_R = 8'h72;
	localparam logic [7:0] CHR_LOW_T = 8'h74;
	localparam logic [7:0] CHR_LOW_U = 8'h75;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_LOW_A = 8'h61;
	localparam logic [7:0] CHR_PRINT_LO = 8'h20;
	localparam logic [7:0] CHR_PRINT_HI = 8'h7E;

	typedef struct packed {
		logic       open_q;
		logic       close_q;
		logic [1:0] kind;
		logic [7:0] chr;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [2:0] body_len(input logic [1:0] kind);
		logic [2:0] len;
		case (kind)
			KIND_RAW: len = 3'd1;
			KIND_ESC: len = 3'd2;
			KIND_UNI: len = 3'd6;
			default:  len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10)
			c = CHR_ZERO + {4'd0, nib};
		else
			c = CHR_LOW_A + {4'd0, nib} - 8'd10;
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- sv/jse_front.sv -----
// Front end: accepts input beats, classifies the byte, pushes a descriptor.
`timescale 1ns / 1ps
`default_nettype none
module jse_front
	import jse_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_byte,
	input  wire logic       starts_string,
	input  wire logic       ends_string,
	input  wire qstat_t     q_stat,
	output logic            push,
	output desc_t           push_desc
);

	logic       is_esc;
	logic [7:0] esc_chr;

	assign in_stall = q_stat.full;

	always_comb begin
		is_esc  = 1'b1;
		esc_chr = data_byte;
		case (data_byte)
			CHR_QUOTE:  esc_chr = CHR_QUOTE;
			CHR_BSLASH: esc_chr = CHR_BSLASH;
			CHR_SLASH:  esc_chr = CHR_SLASH;
			CHR_BS:     esc_chr = CHR_LOW_B;
			CHR_FF:     esc_chr = CHR_LOW_F;
			CHR_LF:     esc_chr = CHR_LOW_N;
			CHR_CR:     esc_chr = CHR_LOW_R;
			CHR_TAB:    esc_chr = CHR_LOW_T;
			default:    is_esc  = 1'b0;
		endcase
	end

	always_comb begin
		push_desc.open_q  = starts_string;
		push_desc.close_q = ends_string;
		push_desc.chr     = data_byte;
		if (!has_byte) begin
			push_desc.kind = KIND_NONE;
		end else if (is_esc) begin
			push_desc.kind = KIND_ESC;
			push_desc.chr  = esc_chr;
		end else if (data_byte >= CHR_PRINT_LO && data_byte <= CHR_PRINT_HI) begin
			push_desc.kind = KIND_RAW;
		end else begin
			push_desc.kind = KIND_UNI;
		end
	end

	// Drop beats that produce no output at all
	assign push = in_valid && !q_stat.full && (has_byte || starts_string || ends_string);

endmodule
`default_nettype wire

// ----- sv/jse_fifo.sv -----
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module jse_fifo
	import jse_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output desc_t      head,
	output qstat_t     q_stat
);

	desc_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/jse_back.sv -----
// Back end: expands one descriptor into output beats through an output register.
`timescale 1ns / 1ps
`default_nettype none
module jse_back
	import jse_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire desc_t head,
	input  wire qstat_t q_stat,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

`include "json_string_escaper_unit_assert.svh"

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	logic       have;
	logic       load;
	logic [2:0] blen;
	logic [3:0] total;
	logic [2:0] body_pos;
	logic [7:0] body_chr;
	logic [7:0] next_byte;
	logic       next_last;

	assign have  = !q_stat.empty;
	assign load  = have && (!out_valid_q || !out_stall);
	assign pop   = load && next_last;
	assign blen  = body_len(head.kind);
	assign total = {3'd0, head.open_q} + {1'b0, blen} + {3'd0, head.close_q};
	assign body_pos = step_q - {2'd0, head.open_q};

	always_comb begin
		body_chr = head.chr;
		case (head.kind)
			KIND_ESC: begin
				if (body_pos == 3'd0)
					body_chr = CHR_BSLASH;
			end
			KIND_UNI: begin
				case (body_pos)
					3'd0:    body_chr = CHR_BSLASH;
					3'd1:    body_chr = CHR_LOW_U;
					3'd2:    body_chr = CHR_ZERO;
					3'd3:    body_chr = CHR_ZERO;
					3'd4:    body_chr = hex_lower(head.chr[7:4]);
					default: body_chr = hex_lower(head.chr[3:0]);
				endcase
			end
			default: body_chr = head.chr;
		endcase
	end

	always_comb begin
		if (head.open_q && step_q == 3'd0)
			next_byte = CHR_QUOTE;
		else if (body_pos < blen)
			next_byte = body_chr;
		else
			next_byte = CHR_QUOTE;
		next_last = ({1'b0, step_q} == total - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				step_q <= next_last ? 3'd0 : step_q + 3'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_last_q <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	// Mid-run step must have its descriptor still queued
	`JSE_ASSERT_NOW(a_step_has_desc, step_q != 3'd0, !q_stat.empty)
	// Step never runs past the descriptor's length
	`JSE_ASSERT_NOW(a_step_in_range, !q_stat.empty, {1'b0, step_q} < total)
	// Finishing a run rewinds the step counter
	`JSE_ASSERT_NEXT(a_rewind, load && next_last, step_q == 3'd0 && run_last)

endmodule
`default_nettype wire

// ----- sv/json_string_escaper_unit.sv -----
// Top level of the JSON string escaper: front end, descriptor queue, back end.
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall   | data_byte, has_byte, starts_string, ends_string
//  output  | out       | out_valid/out_stall | out_byte, run_last
//
// One input beat is accepted per cycle while the 4-entry descriptor queue has room.
// Each item yields 0 to 8 output beats, one per cycle while out_stall is low; the back
// end's expansion counter sets the output rate, while the queue keeps taking items.
// Input to first output beat passes the queue write, then the output register.
// Reset (arst_n low) empties the queue and clears the output valid; no clearing pass.
// in_stall is high only while the queue is full; out_stall holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module json_string_escaper_unit
	import jse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_byte,
	input  wire logic       starts_string,
	input  wire logic       ends_string,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	qstat_t q_stat;
	desc_t  push_desc;
	desc_t  head;
	logic   push;
	logic   pop;

	jse_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.has_byte      (has_byte),
		.starts_string (starts_string),
		.ends_string   (ends_string),
		.q_stat        (q_stat),
		.push          (push),
		.push_desc     (push_desc)
	);

	jse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule
`default_nettype wire

// ----- dv/json_string_escaper_checker.sv -----
// Checker for json_string_escaper_unit: predicts the escaped text and compares output beats.
`timescale 1ns / 1ps
module json_string_escaper_checker
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       starts_string,
	input  logic       ends_string,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	output int         mismatches,
	output int         beats_owed
);

	localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_beat_t;

	text_beat_t escaped_text_q[$];
	int fail_count = 0;
	int owed_count = 0;

	assign mismatches = fail_count;
	assign beats_owed = owed_count;

	task automatic report_mismatch(input string what);
		$display("[%0t] escaper check: %s", $time, what);
		fail_count++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return HEX_DIGITS[127 - 8 * nib -: 8];
	endfunction

	// Queue the quoted, escaped text that one input beat must produce.
	task automatic predict_escape(input logic [7:0] b, input logic has, input logic st,
			input logic en);
		logic [7:0] text[$];
		logic [7:0] letter;
		bit         short_escape;
		text_beat_t beat;
		letter = b;
		short_escape = 1'b1;
		if (st)
			text.push_back(CHR_QUOTE);
		if (has) begin
			case (b)
				CHR_QUOTE, CHR_BSLASH, CHR_SLASH: letter = b;
				CHR_BS:  letter = CHR_LOW_B;
				CHR_FF:  letter = CHR_LOW_F;
				CHR_LF:  letter = CHR_LOW_N;
				CHR_CR:  letter = CHR_LOW_R;
				CHR_TAB: letter = CHR_LOW_T;
				default: short_escape = 1'b0;
			endcase
			if (short_escape) begin
				text.push_back(CHR_BSLASH);
				text.push_back(letter);
			end else if (b >= CHR_PRINT_LO && b <= CHR_PRINT_HI) begin
				text.push_back(b);
			end else begin
				text.push_back(CHR_BSLASH);
				text.push_back(CHR_LOW_U);
				text.push_back(CHR_ZERO);
				text.push_back(CHR_ZERO);
				text.push_back(hex_char(b[7:4]));
				text.push_back(hex_char(b[3:0]));
			end
		end
		if (en)
			text.push_back(CHR_QUOTE);
		foreach (text[k]) begin
			beat.text = text[k];
			beat.last = (k == text.size() - 1);
			escaped_text_q.push_back(beat);
		end
	endtask

	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n) begin
			// Pop before push: an input beat cannot produce output on its own edge.
			if (out_valid && !out_stall) begin
				if (escaped_text_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output beat %02h last %0b",
						out_byte, run_last));
				end else begin
					want = escaped_text_q.pop_front();
					if (out_byte !== want.text)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.text));
					if (run_last !== want.last)
						report_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
							run_last, want.last, want.text));
				end
			end
			if (in_valid && !in_stall)
				predict_escape(data_byte, has_byte, starts_string, ends_string);
			owed_count <= escaped_text_q.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// Testbench top for json_string_escaper_unit: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
	import jse_pkg::*;

	localparam int ITEM_TARGET    = 210;
	localparam int LONG_HOLD      = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_TAIL     = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       has_byte = 1'b0;
	logic       starts_string = 1'b0;
	logic       ends_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	int mismatches;
	int beats_owed;
	int items_sent = 0;
	int idle_cycles = 0;
	int hold_off_asked = 0;
	int tx_stretch_left = 0;
	bit tx_eager = 1'b0;

	always #4 clk = ~clk;

	json_string_escaper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.starts_string(starts_string),
		.ends_string(ends_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last)
	);

	json_string_escaper_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.starts_string(starts_string),
		.ends_string(ends_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.mismatches(mismatches),
		.beats_owed(beats_owed)
	);

	// Sender alternates stretches of back-to-back beats with stretches of random gaps.
	function automatic int sender_gap();
		if (tx_stretch_left == 0) begin
			tx_stretch_left = $urandom_range(6, 30);
			tx_eager = ($urandom_range(0, 2) == 0);
		end
		tx_stretch_left--;
		return tx_eager ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: b = CHR_QUOTE;
					1: b = CHR_BSLASH;
					2: b = CHR_SLASH;
					3: b = CHR_BS;
					4: b = CHR_FF;
					5: b = CHR_LF;
					6: b = CHR_CR;
					default: b = CHR_TAB;
				endcase
			end
			1: b = 8'($urandom_range(0, 31));
			2: b = 8'h7F;
			3, 4: b = 8'($urandom_range(128, 255));
			default: b = 8'($urandom_range(32, 126));
		endcase
		return b;
	endfunction

	task automatic offer_item(input logic [7:0] b, input logic has, input logic st,
			input logic en, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= has;
		starts_string <= st;
		ends_string <= en;
		do @(posedge clk); while (in_stall);
		if (has || st || en)
			items_sent++;
	endtask

	task automatic send_string(input int len);
		if (len == 0)
			offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1, sender_gap());
		for (int i = 0; i < len; i++)
			offer_item(pick_text_byte(), 1'b1, i == 0, i == len - 1, sender_gap());
	endtask

	// Hold the input idle until every predicted beat has come out.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		bit pressure_done;
		bit paused;
		int len;
		pressure_done = 1'b0;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Quote-only items, an empty string and an item that yields nothing
		offer_item(8'hFF, 1'b0, 1'b1, 1'b1, sender_gap());
		offer_item(8'hFF, 1'b0, 1'b0, 1'b0, sender_gap());
		offer_item(8'h00, 1'b0, 1'b1, 1'b0, sender_gap());
		offer_item(8'hA5, 1'b0, 1'b0, 1'b1, sender_gap());
		// Every short escape, as one string
		offer_item(CHR_QUOTE, 1'b1, 1'b1, 1'b0, sender_gap());
		offer_item(CHR_BSLASH, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_SLASH, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_BS, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_FF, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_LF, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_CR, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(CHR_TAB, 1'b1, 1'b0, 1'b1, sender_gap());
		// Edges of the printable range and the hex escapes
		offer_item(8'h00, 1'b1, 1'b1, 1'b0, sender_gap());
		offer_item(8'h1F, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'h20, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'h7E, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'h7F, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'h80, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'hAB, 1'b1, 1'b0, 1'b0, sender_gap());
		offer_item(8'hFF, 1'b1, 1'b0, 1'b1, sender_gap());
		// Longest expansion: both quotes around a hex escape
		offer_item(8'hFF, 1'b1, 1'b1, 1'b1, sender_gap());
		wait_for_drain();

		while (items_sent < ITEM_TARGET) begin
			if (!pressure_done && items_sent >= 80) begin
				// Stall the output for a long stretch while beats keep coming.
				hold_off_asked <= hold_off_asked + 1;
				for (int i = 0; i < 10; i++)
					offer_item(8'($urandom_range(128, 255)), 1'b1, 1'b1, 1'b1, 0);
				pressure_done = 1'b1;
			end else if (!paused && items_sent >= 140) begin
				wait_for_drain();
				paused = 1'b1;
			end else begin
				case ($urandom_range(0, 7))
					0: offer_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sender_gap());
					1: begin
						// Broken string: opened but never closed
						len = $urandom_range(1, 4);
						for (int i = 0; i < len; i++)
							offer_item(pick_text_byte(), 1'b1, i == 0, 1'b0, sender_gap());
					end
					default: begin
						len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
							: $urandom_range(0, 6);
						send_string(len);
					end
				endcase
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("json_string_escaper_unit regression: pass");
		else
			$display("json_string_escaper_unit regression: fail");
		$finish;
	end

	initial begin : receiver
		int hold;
		int stretch_left;
		int holds_served;
		bit lazy;
		stretch_left = 0;
		holds_served = 0;
		lazy = 1'b0;
		forever begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(8, 40);
				lazy = ($urandom_range(0, 2) != 0);
			end
			stretch_left--;
			hold = lazy ? int'($urandom_range(0, 16)) : 0;
			if (hold_off_asked != holds_served) begin
				hold += LONG_HOLD;
				holds_served = hold_off_asked;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("json_string_escaper_unit regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
